// ----- design/anfp_pkg.sv -----
`default_nettype none

package anfp_pkg;

  localparam int MAX_RES  = 3;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef enum logic [1:0] {
    MODE_UDEC  = 2'd0,
    MODE_SDEC  = 2'd1,
    MODE_FIXED = 2'd2,
    MODE_HEX   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    END_STOP    = 2'd0,
    END_INVALID = 2'd1,
    END_STRING  = 2'd2,
    END_LIMIT   = 2'd3
  } reason_t;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_HELD = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  localparam logic [1:0] CFG_PARSE_MODE     = 2'd0;
  localparam logic [1:0] CFG_STOP_CHAR      = 2'd1;
  localparam logic [1:0] CFG_MAX_HEX_DIGITS = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [4:0] DIG_CNT_MAX  = 5'd31;
  localparam logic [7:0] FRAC_CNT_MAX = 8'd255;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] stop;
    logic [4:0] max_hex;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [63:0] acc;
    logic        minus;
    logic        dot;
    logic [7:0]  frac;
    logic [4:0]  dcnt;
    logic        held;
    logic        open;
    logic        wrap;
  } fstate_t;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  frac_digits;
    logic [1:0]  end_reason;
    logic        overflowed;
    logic        run_last;
  } res_t;

  typedef struct packed {
    fstate_t st;
    logic    emit;
    res_t    res;
    logic    consumed;
  } op_t;

  typedef struct packed {
    logic [1:0]       n;
    res_t [MAX_RES-1:0] res;
  } push_t;

  function automatic fstate_t fs_clear();
    fstate_t s;
    s       = '0;
    s.phase = PH_LEAD;
    return s;
  endfunction

  function automatic res_t make_res(fstate_t s, cfg_t cfg, reason_t r);
    res_t        o;
    logic [31:0] lo;
    o  = '0;
    lo = s.acc[31:0];
    if (cfg.mode == MODE_HEX) begin
      o.value = s.acc;
    end else begin
      if (cfg.mode != MODE_UDEC && s.minus) begin
        lo = ~lo + 32'd1;
      end
      o.value = {32'd0, lo};
    end
    if (r == END_INVALID && (cfg.mode == MODE_SDEC || cfg.mode == MODE_HEX)) begin
      o.value = '0;
    end
    o.frac_digits = (cfg.mode == MODE_FIXED) ? s.frac : 8'd0;
    o.end_reason  = r;
    o.overflowed  = s.wrap;
    o.run_last    = 1'b0;
    return o;
  endfunction

  function automatic op_t body_op(fstate_t s, logic [7:0] c, cfg_t cfg);
    op_t         o;
    logic        is_dig;
    logic [3:0]  dv;
    logic [4:0]  lim;
    logic [35:0] n;
    o          = '0;
    o.st       = s;
    o.consumed = 1'b1;
    lim        = (cfg.max_hex == 5'd0) ? 5'd1 : cfg.max_hex;
    is_dig     = 1'b0;
    dv         = c[3:0];
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      is_dig = 1'b1;
    end else if (cfg.mode == MODE_HEX &&
                 (c inside {[CH_LO_A:CH_LO_F]} || c inside {[CH_UP_A:CH_UP_F]})) begin
      is_dig = 1'b1;
      dv     = c[3:0] + 4'd9;
    end
    n = ({4'd0, s.acc[31:0]} << 3) + ({4'd0, s.acc[31:0]} << 1) + {32'd0, dv};
    if (c == cfg.stop) begin
      o.emit = 1'b1;
      o.res  = make_res(s, cfg, END_STOP);
      o.st   = fs_clear();
    end else if (cfg.mode == MODE_HEX && s.dcnt >= lim) begin
      o.emit     = 1'b1;
      o.res      = make_res(s, cfg, END_LIMIT);
      o.st       = fs_clear();
      o.consumed = 1'b0;
    end else if (is_dig) begin
      if (cfg.mode == MODE_HEX) begin
        if (s.acc[63:60] != 4'd0) o.st.wrap = 1'b1;
        o.st.acc = {s.acc[59:0], dv};
        if (s.dcnt < DIG_CNT_MAX) o.st.dcnt = s.dcnt + 5'd1;
      end else begin
        if (n[35:32] != 4'd0) o.st.wrap = 1'b1;
        o.st.acc = {32'd0, n[31:0]};
        if (cfg.mode == MODE_FIXED && s.dot && s.frac < FRAC_CNT_MAX) begin
          o.st.frac = s.frac + 8'd1;
        end
      end
    end else if (c == CH_SPACE) begin
      o.st = s;
    end else if (c == CH_DOT && cfg.mode == MODE_FIXED) begin
      o.st.dot = 1'b1;
    end else begin
      o.emit = 1'b1;
      o.res  = make_res(s, cfg, END_INVALID);
      o.st   = fs_clear();
    end
    return o;
  endfunction

  function automatic op_t feed_round(fstate_t s, logic [7:0] c, cfg_t cfg);
    op_t     o;
    fstate_t t;
    o          = '0;
    t          = s;
    t.open     = 1'b1;
    o.st       = t;
    o.consumed = 1'b1;
    if (s.phase == PH_LEAD) begin
      if (c == CH_SPACE) begin
        o.st = t;
      end else if ((cfg.mode == MODE_SDEC || cfg.mode == MODE_FIXED) &&
                   (c == CH_MINUS || c == CH_PLUS)) begin
        o.st.minus = (c == CH_MINUS);
        o.st.phase = PH_BODY;
      end else if (cfg.mode == MODE_HEX && c == CH_ZERO) begin
        o.st.held  = 1'b1;
        o.st.phase = PH_HELD;
      end else begin
        t.phase = PH_BODY;
        o       = body_op(t, c, cfg);
      end
    end else begin
      o = body_op(t, c, cfg);
    end
    return o;
  endfunction

  // a held zero only exists in a fresh field, so its digit adds nothing to the value
  function automatic op_t release_op(fstate_t s, cfg_t cfg);
    op_t     o;
    o          = '0;
    o.st       = s;
    o.st.held  = 1'b0;
    o.st.phase = PH_BODY;
    o.consumed = 1'b1;
    if (cfg.stop == CH_ZERO) begin
      o.emit = 1'b1;
      o.res  = make_res(o.st, cfg, END_STOP);
      o.st   = fs_clear();
    end else if (cfg.mode == MODE_HEX && s.dcnt < DIG_CNT_MAX) begin
      o.st.dcnt = s.dcnt + 5'd1;
    end
    return o;
  endfunction

  function automatic push_t push_add(push_t p, res_t r);
    push_t q;
    q = p;
    case (p.n)
      2'd0:    q.res[0] = r;
      2'd1:    q.res[1] = r;
      default: q.res[2] = r;
    endcase
    q.n = p.n + 2'd1;
    return q;
  endfunction

  function automatic push_t push_mark_last(push_t p);
    push_t q;
    q = p;
    case (p.n)
      2'd1:    q.res[0].run_last = 1'b1;
      2'd2:    q.res[1].run_last = 1'b1;
      2'd3:    q.res[2].run_last = 1'b1;
      default: q = p;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// ----- design/anfp_if.sv -----
`default_nettype none

interface anfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface anfp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [7:0]  frac_digits;
  logic [1:0]  end_reason;
  logic        overflowed;
  logic        run_last;

  modport source (output valid, output value, output frac_digits, output end_reason,
                  output overflowed, output run_last, input ready);
  modport sink   (input valid, input value, input frac_digits, input end_reason,
                  input overflowed, input run_last, output ready);
endinterface

`default_nettype wire

// ----- design/anfp_parse.sv -----
`default_nettype none

module anfp_parse (
  input  wire               clk,
  input  wire               rst_n,
  anfp_in_if.sink           in_chan,
  input  anfp_pkg::cfg_t    cfg,
  input  wire               room,
  output anfp_pkg::push_t   push
);

  logic             in_v_r;
  logic [7:0]       char_r;
  logic             last_r;
  anfp_pkg::fstate_t state_r;
  anfp_pkg::fstate_t state_nxt;
  anfp_pkg::push_t   step_push;
  logic             adv;

  assign adv           = in_v_r && room;
  assign in_chan.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      char_r <= in_chan.char_code;
      last_r <= in_chan.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= anfp_pkg::fs_clear();
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    anfp_pkg::fstate_t s;
    anfp_pkg::op_t     op;
    anfp_pkg::push_t   p;
    p  = '0;
    op = '0;
    s  = state_r;
    if (s.held && cfg.mode == anfp_pkg::MODE_HEX &&
        (char_r == anfp_pkg::CH_X_LO || char_r == anfp_pkg::CH_X_UP)) begin
      // 0x prefix dropped
      s.held  = 1'b0;
      s.phase = anfp_pkg::PH_BODY;
      s.open  = 1'b1;
    end else begin
      if (s.held) begin
        op = anfp_pkg::release_op(s, cfg);
        if (op.emit) p = anfp_pkg::push_add(p, op.res);
        s = op.st;
      end
      op = anfp_pkg::feed_round(s, char_r, cfg);
      if (op.emit) p = anfp_pkg::push_add(p, op.res);
      if (!op.consumed) begin
        // digit limit hit: the char starts the next field
        op = anfp_pkg::feed_round(anfp_pkg::fs_clear(), char_r, cfg);
        if (op.emit) p = anfp_pkg::push_add(p, op.res);
      end
      s = op.st;
    end
    if (last_r) begin
      if (s.held) begin
        op = anfp_pkg::release_op(s, cfg);
        if (op.emit) p = anfp_pkg::push_add(p, op.res);
        s = op.st;
      end
      if (s.open) p = anfp_pkg::push_add(p, anfp_pkg::make_res(s, cfg, anfp_pkg::END_STRING));
      s = anfp_pkg::fs_clear();
    end
    step_push = anfp_pkg::push_mark_last(p);
    state_nxt = adv ? s : state_r;
  end

  assign push = adv ? step_push : '0;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_r) |=> (!state_r.open && !state_r.held && state_r.phase == anfp_pkg::PH_LEAD))
    else $error("field state not cleared after end of string");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_r) |-> (push.n != 2'd0))
    else $error("end of string produced no result");

  a_held_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.held |-> (state_r.acc == 64'd0 && state_r.dcnt == 5'd0 &&
                      state_r.phase == anfp_pkg::PH_HELD))
    else $error("held zero outside a fresh field");

endmodule

`default_nettype wire

// ----- design/anfp_outq.sv -----
`default_nettype none

module anfp_outq (
  input  wire              clk,
  input  wire              rst_n,
  input  anfp_pkg::push_t  push,
  output logic             room,
  anfp_out_if.source       out_chan
);

  anfp_pkg::res_t                      mem [anfp_pkg::OQ_DEPTH];
  logic [anfp_pkg::OQ_AW-1:0]          wr_r;
  logic [anfp_pkg::OQ_AW-1:0]          rd_r;
  logic [anfp_pkg::OQ_CW-1:0]          count_r;
  logic                                pop;
  anfp_pkg::res_t                      head;

  assign pop            = out_chan.valid && out_chan.ready;
  assign out_chan.valid = (count_r != '0);
  assign head           = mem[rd_r];

  assign out_chan.value       = head.value;
  assign out_chan.frac_digits = head.frac_digits;
  assign out_chan.end_reason  = head.end_reason;
  assign out_chan.overflowed  = head.overflowed;
  assign out_chan.run_last    = head.run_last;

  // room for a full set of results from one char after this cycle's transfer
  assign room = (count_r <= anfp_pkg::OQ_CW'(anfp_pkg::OQ_DEPTH - anfp_pkg::MAX_RES)) ||
                (pop && count_r == anfp_pkg::OQ_CW'(anfp_pkg::OQ_DEPTH - anfp_pkg::MAX_RES + 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_r + anfp_pkg::OQ_AW'(push.n);
      rd_r    <= rd_r + anfp_pkg::OQ_AW'(pop);
      count_r <= count_r + anfp_pkg::OQ_CW'(push.n) - anfp_pkg::OQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < anfp_pkg::MAX_RES; k++) begin
      if (2'(k) < push.n) begin
        mem[wr_r + anfp_pkg::OQ_AW'(k)] <= push.res[k];
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= anfp_pkg::OQ_CW'(anfp_pkg::OQ_DEPTH))
    else $error("result queue overrun");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |=> (count_r != '0))
    else $error("pushed result not visible");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0 && !pop) |=>
      (count_r == $past(count_r) + anfp_pkg::OQ_CW'($past(push.n))))
    else $error("queue count mismatch");

endmodule

`default_nettype wire

// ----- design/ascii_number_field_parser.sv -----
// results of a character reach out_chan after the input register and the result queue,
//   and wait longer when older results still sit in the result queue
// throughput: one character per cycle while each character yields at most one result and
//   out_chan is ready; input stalls unless the four-entry queue has room for three results
// reset: rst_n synchronous, active low; clears field state and the result queue and
//   loads parse_mode 1, stop_char 44 and max_hex_digits 16
`default_nettype none

module ascii_number_field_parser (
  input  wire        clk,
  input  wire        rst_n,
  anfp_in_if.sink    in_chan,
  anfp_out_if.source out_chan,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [7:0]  cfg_data
);

  anfp_pkg::cfg_t  cfg_r;
  anfp_pkg::push_t push;
  logic            room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= anfp_pkg::MODE_SDEC;
      cfg_r.stop    <= 8'd44;
      cfg_r.max_hex <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        anfp_pkg::CFG_PARSE_MODE:     cfg_r.mode    <= anfp_pkg::mode_t'(cfg_data[1:0]);
        anfp_pkg::CFG_STOP_CHAR:      cfg_r.stop    <= cfg_data;
        anfp_pkg::CFG_MAX_HEX_DIGITS: cfg_r.max_hex <= cfg_data[4:0];
        default:                      cfg_r         <= cfg_r;
      endcase
    end
  end

  anfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .room    (room),
    .push    (push)
  );

  anfp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
